// File: design/sarf_pkg.sv
// Shared types and constants for the sensor acknowledge frame receiver.
package sarf_pkg;

  localparam int unsigned FRAME_MAX  = 128;
  localparam int unsigned HEAD_BYTES = 9;
  localparam int unsigned MIN_LEN    = 3;
  localparam int unsigned LEN_MAX    = FRAME_MAX - HEAD_BYTES;
  localparam int unsigned LEN_W      = $clog2(LEN_MAX + 1);

  localparam logic [7:0] HDR_FIRST  = 8'hEF;
  localparam logic [7:0] HDR_SECOND = 8'h01;
  localparam logic [7:0] ACK_ID     = 8'h07;

  localparam logic [3:0] POS_FIRST  = 4'd2;
  localparam logic [3:0] POS_ID     = 4'd6;
  localparam logic [3:0] POS_LEN_HI = 4'd7;
  localparam logic [3:0] POS_LEN_LO = 4'd8;

  localparam logic [15:0] MIN_LEN16 = 16'(MIN_LEN);
  localparam logic [15:0] LEN_MAX16 = 16'(LEN_MAX);

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_SAW_EF = 2'd1,
    PH_HEADER = 2'd2,
    PH_BODY   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_CONFIRM = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_ID  = 2'd2
  } status_e;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    status_e    status;
    logic [6:0] count;
    logic       frame_end;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } byte_t;

endpackage

// File: design/sarf_rx_if.sv
// Channel carrying received bytes into the frame receiver.
interface sarf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: design/sarf_res_if.sv
// Channel carrying result items out of the frame receiver.
interface sarf_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] data_byte;
  logic [1:0] frame_status;
  logic [6:0] copied_count;
  logic       frame_end;

  modport source (output valid, output item_kind, output data_byte, output frame_status,
                  output copied_count, output frame_end, input ready);
  modport sink   (input valid, input item_kind, input data_byte, input frame_status,
                  input copied_count, input frame_end, output ready);
endinterface

// File: design/sarf_in_reg.sv
// Input register: holds one received byte until the parser takes it.
module sarf_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  output logic            in_ready_o,
  output sarf_pkg::byte_t q_o
);
  import sarf_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       load;

  assign in_ready_o = adv_i || !valid_q;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (adv_i || !valid_q) begin
      valid_d = load;
      byte_d  = in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign q_o = '{valid: valid_q, rx_byte: byte_q};
endmodule

// File: design/sarf_parser.sv
// Frame parser: header hunt, length check and per-byte result decision.
module sarf_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      rx_byte_i,
  input  logic [6:0]      capacity_i,
  output sarf_pkg::res_t  res_o
);
  import sarf_pkg::*;

  phase_e           phase_q, phase_d;
  logic [3:0]       pos_q, pos_d;
  logic [7:0]       len_hi_q, len_hi_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic             id_q, id_d;
  logic             seen_q, seen_d;
  logic [6:0]       sent_q, sent_d;
  logic [15:0]      full_len;
  logic             bad_len;

  assign full_len = {len_hi_q, rx_byte_i};
  assign bad_len  = (full_len < MIN_LEN16) || (full_len > LEN_MAX16);

  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == HDR_FIRST) phase_d = PH_SAW_EF;
        end
        PH_SAW_EF: begin
          if (rx_byte_i == HDR_SECOND) phase_d = PH_HEADER;
          else if (rx_byte_i != HDR_FIRST) phase_d = PH_HUNT;
        end
        PH_HEADER: begin
          if (pos_q == POS_LEN_LO) phase_d = bad_len ? PH_HUNT : PH_BODY;
        end
        PH_BODY: begin
          if (rem_q == LEN_W'(1)) phase_d = PH_HUNT;
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    pos_d    = pos_q;
    len_hi_d = len_hi_q;
    rem_d    = rem_q;
    id_d     = id_q;
    seen_d   = seen_q;
    sent_d   = sent_q;
    res_o    = '{valid: 1'b0, kind: KIND_CONFIRM, data: 8'd0, status: ST_OK,
                 count: 7'd0, frame_end: 1'b0};
    if (step_i) begin
      unique case (phase_q)
        PH_HUNT: ;
        PH_SAW_EF: begin
          if (rx_byte_i == HDR_SECOND) pos_d = POS_FIRST;
        end
        PH_HEADER: begin
          pos_d = pos_q + 4'd1;
          if (pos_q == POS_ID) id_d = (rx_byte_i == ACK_ID);
          if (pos_q == POS_LEN_HI) len_hi_d = rx_byte_i;
          if (pos_q == POS_LEN_LO) begin
            pos_d  = 4'd0;
            sent_d = 7'd0;
            seen_d = 1'b0;
            rem_d  = full_len[LEN_W-1:0];
            if (bad_len) begin
              res_o = '{valid: 1'b1, kind: KIND_STATUS, data: 8'd0, status: ST_BAD_LEN,
                        count: 7'd0, frame_end: 1'b1};
            end
          end
        end
        PH_BODY: begin
          rem_d = rem_q - LEN_W'(1);
          if (!seen_q) begin
            seen_d = 1'b1;
            if (id_q) begin
              res_o = '{valid: 1'b1, kind: KIND_CONFIRM, data: rx_byte_i, status: ST_OK,
                        count: 7'd0, frame_end: 1'b0};
            end
          end else if (rem_q > LEN_W'(2)) begin
            if (id_q && (sent_q < capacity_i)) begin
              sent_d = sent_q + 7'd1;
              res_o  = '{valid: 1'b1, kind: KIND_PAYLOAD, data: rx_byte_i, status: ST_OK,
                         count: 7'd0, frame_end: 1'b0};
            end
          end
          if (rem_q == LEN_W'(1)) begin
            pos_d  = 4'd0;
            sent_d = 7'd0;
            res_o  = '{valid: 1'b1, kind: KIND_STATUS, data: 8'd0,
                       status: id_q ? ST_OK : ST_BAD_ID,
                       count: id_q ? sent_q : 7'd0, frame_end: 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      pos_q    <= 4'd0;
      len_hi_q <= 8'd0;
      rem_q    <= '0;
      id_q     <= 1'b0;
      seen_q   <= 1'b0;
      sent_q   <= 7'd0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      len_hi_q <= len_hi_d;
      rem_q    <= rem_d;
      id_q     <= id_d;
      seen_q   <= seen_d;
      sent_q   <= sent_d;
    end
  end
endmodule

// File: design/sarf_out_reg.sv
// Result register: holds one result item until the sink takes it.
module sarf_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  sarf_pkg::res_t res_i,
  output sarf_pkg::res_t q_o
);
  import sarf_pkg::*;

  logic valid_q, valid_d;
  res_t res_q, res_d;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (adv_i) begin
      valid_d = res_i.valid;
      res_d   = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_comb begin
    q_o       = res_q;
    q_o.valid = valid_q;
  end
endmodule

// File: design/sensor_ack_frame_receiver_unit.sv
// Top level of the sensor acknowledge frame receiver.
//
// rx_i takes one received byte per transaction. res_o gives result items:
// the confirm code, payload bytes up to the capacity register, and one
// status item closing each frame (ok, bad declared length, wrong id) with
// the number of payload bytes passed on.
// cfg_we_i/cfg_wdata_i write the payload capacity; reset value 116.
// A byte passes through an input register and then the parser, whose
// result lands in the result register that drives res_o. One byte per
// cycle is sustained while the sink does not stall; the parser state
// update is a single pass per byte.
// Bytes that cause no result only advance the parser state.
// Reset empties both registers and puts the parser in header hunt.
// When the sink stalls with a result waiting, the result register and the
// input register both hold; rx_i.ready stays high only while the input
// register is empty, so at most one more byte is taken.
module sensor_ack_frame_receiver_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  sarf_rx_if.sink    rx_i,
  sarf_res_if.source res_o
);
  import sarf_pkg::*;

  logic       adv;
  logic [6:0] cap_q, cap_d;
  byte_t      in_q;
  res_t       res_c;
  res_t       out_q;

  assign adv = !out_q.valid || res_o.ready;

  assign cap_d = cfg_we_i ? cfg_wdata_i : cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 7'd116;
    end else begin
      cap_q <= cap_d;
    end
  end

  sarf_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (rx_i.valid),
    .in_byte_i  (rx_i.rx_byte),
    .in_ready_o (rx_i.ready),
    .q_o        (in_q)
  );

  sarf_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (adv && in_q.valid),
    .rx_byte_i  (in_q.rx_byte),
    .capacity_i (cap_q),
    .res_o      (res_c)
  );

  sarf_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .res_i  (res_c),
    .q_o    (out_q)
  );

  assign res_o.valid        = out_q.valid;
  assign res_o.item_kind    = out_q.kind;
  assign res_o.data_byte    = out_q.data;
  assign res_o.frame_status = out_q.status;
  assign res_o.copied_count = out_q.count;
  assign res_o.frame_end    = out_q.frame_end;
endmodule
